@@ hw/rtl/drd_pkg.sv @@
// Shared types, widths and codes for the delta run-length decoder.
package drd_pkg;

    localparam int WORD_W      = 16;
    localparam int LIMIT_W     = 32;
    localparam int DEF_MAX_RUN = 64;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CNT   = 2'd1;
    localparam logic [1:0] PH_INC   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_EVEN = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    localparam logic CFG_SIGNED = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = '1;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] value;
        logic              value_valid;
        logic              run_last;
        logic              done;
        logic [1:0]        status;
    } t_res;

endpackage

@@ hw/rtl/drd_unit.sv @@
// Shared adder, emitted-count incrementer and limit comparators used by the decode sequencer.
module drd_unit (
    input  logic [drd_pkg::WORD_W-1:0]  i_a,
    input  logic [drd_pkg::WORD_W-1:0]  i_b,
    input  logic [drd_pkg::LIMIT_W-1:0] i_emitted,
    input  logic [drd_pkg::LIMIT_W-1:0] i_limit,
    output logic [drd_pkg::WORD_W-1:0]  o_sum,
    output logic [drd_pkg::LIMIT_W-1:0] o_emitted_inc,
    output logic                        o_at_limit,
    output logic                        o_hits_limit
);
    import drd_pkg::*;

    assign o_sum         = i_a + i_b;
    assign o_emitted_inc = i_emitted + LIMIT_W'(1);
    assign o_at_limit    = (i_emitted >= i_limit);
    assign o_hits_limit  = (o_emitted_inc == i_limit);

endmodule

@@ hw/rtl/drd_seq.sv @@
// Decode sequencer: word phases, run counter and decoder state.
module drd_seq #(
    parameter int MAX_RUN = drd_pkg::DEF_MAX_RUN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [drd_pkg::WORD_W-1:0]  i_word,
    input  logic                        i_end,
    input  logic                        i_signed,
    input  logic [drd_pkg::LIMIT_W-1:0] i_limit,
    input  logic                        i_slot_free,
    output logic                        o_idle,
    output drd_pkg::t_res               o_res
);
    import drd_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic               r_state, n_state;
    logic [1:0]         r_phase, n_phase;
    logic [WORD_W-1:0]  r_last, n_last;
    logic [WORD_W-1:0]  r_pend, n_pend;
    logic [LIMIT_W-1:0] r_emit, n_emit;
    logic [WORD_W-1:0]  r_inc, n_inc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_end, n_end;

    logic [WORD_W-1:0]  w_sum;
    logic [LIMIT_W-1:0] w_emit_inc;
    logic               w_at_limit;
    logic               w_hits_limit;
    logic [WORD_W-1:0]  w_run;
    logic               w_fin;

    drd_unit u_unit (
        .i_a           (r_last),
        .i_b           (r_inc),
        .i_emitted     (r_emit),
        .i_limit       (i_limit),
        .o_sum         (w_sum),
        .o_emitted_inc (w_emit_inc),
        .o_at_limit    (w_at_limit),
        .o_hits_limit  (w_hits_limit)
    );

    assign o_idle = (r_state == S_IDLE);
    assign w_run  = (i_signed && r_pend[WORD_W-1]) ? '0 : r_pend;
    assign w_fin  = (r_cnt == CNT_W'(1)) || w_hits_limit;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_last  = r_last;
        n_pend  = r_pend;
        n_emit  = r_emit;
        n_inc   = r_inc;
        n_cnt   = r_cnt;
        n_end   = r_end;
        o_res   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    unique case (r_phase)
                        PH_CNT: begin
                            n_pend  = i_word;
                            n_phase = PH_INC;
                            if (i_end) begin
                                o_res.valid    = 1'b1;
                                o_res.run_last = 1'b1;
                                o_res.done     = 1'b1;
                                o_res.status   = ST_EVEN;
                            end
                        end
                        PH_INC: begin
                            n_phase = PH_CNT;
                            if (w_run > WORD_W'(MAX_RUN)) begin
                                o_res.valid    = 1'b1;
                                o_res.run_last = 1'b1;
                                o_res.done     = i_end;
                                o_res.status   = ST_OVER;
                            end else if (w_run == '0 || w_at_limit) begin
                                if (i_end) begin
                                    o_res.valid    = 1'b1;
                                    o_res.run_last = 1'b1;
                                    o_res.done     = 1'b1;
                                    o_res.status   = ST_OK;
                                end
                            end else begin
                                n_state = S_RUN;
                                n_cnt   = w_run[CNT_W-1:0];
                                n_inc   = i_word;
                                n_end   = i_end;
                            end
                        end
                        default: begin
                            n_last  = i_word;
                            n_phase = PH_CNT;
                            if (!w_at_limit) begin
                                n_emit            = w_emit_inc;
                                o_res.valid       = 1'b1;
                                o_res.value       = i_word;
                                o_res.value_valid = 1'b1;
                                o_res.run_last    = 1'b1;
                                o_res.done        = i_end;
                            end else if (i_end) begin
                                o_res.valid    = 1'b1;
                                o_res.run_last = 1'b1;
                                o_res.done     = 1'b1;
                                o_res.status   = ST_OK;
                            end
                        end
                    endcase
                    if (i_end && n_state == S_IDLE) begin
                        n_phase = PH_START;
                        n_pend  = '0;
                        n_emit  = '0;
                    end
                end
            end
            S_RUN: begin
                if (i_slot_free) begin
                    n_last            = w_sum;
                    n_emit            = w_emit_inc;
                    n_cnt             = r_cnt - CNT_W'(1);
                    o_res.valid       = 1'b1;
                    o_res.value       = w_sum;
                    o_res.value_valid = 1'b1;
                    o_res.run_last    = w_fin;
                    o_res.done        = w_fin && r_end;
                    if (w_fin) begin
                        n_state = S_IDLE;
                        if (r_end) begin
                            n_phase = PH_START;
                            n_pend  = '0;
                            n_emit  = '0;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_START;
            r_last  <= '0;
            r_pend  <= '0;
            r_emit  <= '0;
            r_cnt   <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_emit  <= n_emit;
            r_cnt   <= n_cnt;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc <= n_inc;
    end

endmodule

@@ hw/rtl/delta_rle_decoder.sv @@
// Delta run-length decoder top level: config registers, input handshake, output register.
// Results pass through the output register before they reach the master side.
// Start and count words are decoded as they are accepted.
// An increment word with run length N gives up to N adder sums, one per cycle while output is free.
// The output register holds one result; backpressure stalls the run counter.
// Synchronous active-low reset clears decoder state, config registers and output valid.
module delta_rle_decoder #(
    parameter int MAX_RUN = drd_pkg::DEF_MAX_RUN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [drd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [15:0] code_word
    input  logic                        s_axis_tlast,  // stream_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // [15:0] value
    output logic [3:0]                  m_axis_tuser,  // [0] value_valid, [1] run_last, [3:2] status
    output logic                        m_axis_tlast   // stream_done
);
    import drd_pkg::*;

    logic               r_signed;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_ovalid;
    logic [WORD_W-1:0]  r_value;
    logic [3:0]         r_user;
    logic               r_done;

    logic  w_slot_free;
    logic  w_idle;
    logic  w_accept;
    t_res  w_res;

    assign w_slot_free   = !r_ovalid || m_axis_tready;
    assign s_axis_tready = w_idle && w_slot_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    drd_seq #(
        .MAX_RUN (MAX_RUN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (s_axis_tdata[WORD_W-1:0]),
        .i_end       (s_axis_tlast),
        .i_signed    (r_signed),
        .i_limit     (r_limit),
        .i_slot_free (w_slot_free),
        .o_idle      (w_idle),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed <= 1'b0;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIGNED: r_signed <= i_cfg_wdata[0];
                CFG_LIMIT:  r_limit  <= i_cfg_wdata;
                default:    r_signed <= r_signed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res.valid) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_value <= w_res.value;
            r_user  <= {w_res.status, w_res.run_last, w_res.value_valid};
            r_done  <= w_res.done;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_value;
    assign m_axis_tuser  = r_user;
    assign m_axis_tlast  = r_done;

endmodule

@@ hw/rtl/drd_checker.sv @@
// Port-level assertion checker for the delta run-length decoder, with its bind.
module drd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:2] == 2'd0)
        else $error("value beat carries a nonzero status");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("stream end without run end");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0 && m_axis_tuser[1])
        else $error("status beat with value bits or without run end");

endmodule

bind delta_rle_decoder drd_checker u_drd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/delta_rle_checker.sv @@
// Checker for the delta run-length decoder: predicts each result beat and compares it.
module delta_rle_checker #(
    parameter int MAX_RUN = drd_pkg::DEF_MAX_RUN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [drd_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [15:0]                 i_s_tdata,   // [15:0] code_word
    input  logic                        i_s_tlast,   // stream_end
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [15:0]                 i_m_tdata,   // [15:0] value
    input  logic [3:0]                  i_m_tuser,   // [0] value_valid, [1] run_last, [3:2] status
    input  logic                        i_m_tlast,   // stream_done
    output int                          o_errors,
    output int                          o_outstanding,
    output int                          o_results,
    output int                          o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    import drd_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              value_valid;
        logic              run_last;
        logic              stream_done;
        logic [1:0]        status;
    } dec_beat_t;

    dec_beat_t          expected_q[$];
    dec_beat_t          want_beat;

    logic               cfg_signed;
    logic [LIMIT_W-1:0] cfg_limit;

    logic [1:0]         dec_phase;
    logic [WORD_W-1:0]  dec_last;
    logic [WORD_W-1:0]  dec_pending;
    logic [LIMIT_W-1:0] dec_emitted;

    function automatic dec_beat_t make_beat(input logic [WORD_W-1:0] v, input logic vv,
                                            input logic [1:0] st);
        dec_beat_t b;
        b.value       = v;
        b.value_valid = vv;
        b.run_last    = 1'b0;
        b.stream_done = 1'b0;
        b.status      = st;
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            o_errors++;
        end
    endfunction

    task automatic decode_word(input logic [WORD_W-1:0] word, input logic eos);
        dec_beat_t         beats[$];
        dec_beat_t         tail;
        logic [WORD_W-1:0] run_len;
        int unsigned       k;
        case (dec_phase)
            PH_CNT: begin
                dec_pending = word;
                dec_phase   = PH_INC;
                if (eos) beats.push_back(make_beat('0, 1'b0, ST_EVEN));
            end
            PH_INC: begin
                run_len   = dec_pending;
                dec_phase = PH_CNT;
                if (cfg_signed && run_len[WORD_W-1]) run_len = '0;
                if (run_len > MAX_RUN) begin
                    beats.push_back(make_beat('0, 1'b0, ST_OVER));
                end else begin
                    for (k = 0; k < run_len && dec_emitted < cfg_limit; k++) begin
                        dec_last = dec_last + word;
                        beats.push_back(make_beat(dec_last, 1'b1, ST_OK));
                        dec_emitted++;
                    end
                end
            end
            default: begin
                dec_last  = word;
                dec_phase = PH_CNT;
                if (dec_emitted < cfg_limit) begin
                    beats.push_back(make_beat(dec_last, 1'b1, ST_OK));
                    dec_emitted++;
                end
            end
        endcase
        if (eos && beats.size() == 0) beats.push_back(make_beat('0, 1'b0, ST_OK));
        if (beats.size() > 0) begin
            tail          = beats.pop_back();
            tail.run_last = 1'b1;
            if (eos) tail.stream_done = 1'b1;
            beats.push_back(tail);
        end
        if (eos) begin
            dec_phase   = PH_START;
            dec_pending = '0;
            dec_emitted = '0;
        end
        while (beats.size() > 0) expected_q.push_back(beats.pop_front());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            cfg_signed  = 1'b0;
            cfg_limit   = LIMIT_RST;
            dec_phase   = PH_START;
            dec_last    = '0;
            dec_pending = '0;
            dec_emitted = '0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: value 0x%0h tuser 0x%0h tlast %0b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    o_errors++;
                end else begin
                    want_beat = expected_q.pop_front();
                    check_field("value", want_beat.value, i_m_tdata);
                    check_field("value_valid", want_beat.value_valid, i_m_tuser[0]);
                    check_field("run_last", want_beat.run_last, i_m_tuser[1]);
                    check_field("stream_done", want_beat.stream_done, i_m_tlast);
                    check_field("status", want_beat.status, i_m_tuser[3:2]);
                    o_results++;
                    if (!want_beat.value_valid) o_flagged++;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SIGNED) cfg_signed = i_cfg_wdata[0];
                else cfg_limit = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) decode_word(i_s_tdata, i_s_tlast);
        end
        o_outstanding <= expected_q.size();
    end

endmodule

@@ sim/tb_delta_rle_decoder.sv @@
// Testbench top for the delta run-length decoder: stimulus, idling phases and verdict.
module tb_delta_rle_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import drd_pkg::*;

    localparam int     ITEMS_TOTAL   = 450;
    localparam int     N_PHASES      = 8;
    localparam int     SETTLE_CYCLES = 100;
    localparam longint CYCLE_LIMIT   = 1_000_000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_index   = CFG_SIGNED;
    logic [LIMIT_W-1:0] i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic [3:0]         m_axis_tuser;
    logic               m_axis_tlast;

    int                 chk_errors;
    int                 chk_outstanding;
    int                 chk_results;
    int                 chk_flagged;

    int unsigned        tx_idle_pct  = 0;
    int unsigned        rx_stall_pct = 0;
    int unsigned        tx_pct_tab[4] = '{0, 50, 0, 26};
    int unsigned        rx_pct_tab[4] = '{0, 0, 50, 26};
    int                 n_words   = 0;
    int                 n_streams = 0;
    int                 n_configs = 0;
    longint             cycle_count = 0;

    delta_rle_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    delta_rle_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .o_errors      (chk_errors),
        .o_outstanding (chk_outstanding),
        .o_results     (chk_results),
        .o_flagged     (chk_flagged)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("delta_rle_decoder verification failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [WORD_W-1:0] word, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        n_words++;
    endtask

    // hold off until every expected beat is back, then let any silent word finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic sgn, input logic [LIMIT_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SIGNED;
        i_cfg_wdata <= {{(LIMIT_W-1){1'b0}}, sgn};
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= CFG_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_configs++;
    endtask

    function automatic logic [WORD_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return WORD_W'($urandom_range(12));
        if (r < 75) return WORD_W'($urandom_range(64, 13));
        if (r < 82) return '0;
        if (r < 90) return WORD_W'($urandom_range(16'h7FFF, 65));
        return WORD_W'($urandom_range(16'hFFFF, 16'h8000));
    endfunction

    function automatic logic [WORD_W-1:0] pick_inc();
        int unsigned r;
        r = $urandom_range(3);
        if (r == 0) return WORD_W'($urandom_range(3));
        if (r == 1) return WORD_W'($urandom_range(16'hFFFF, 16'hFFFC));
        return WORD_W'($urandom_range(16'hFFFF));
    endfunction

    // well-formed streams mostly; some end on a count word
    task automatic send_random_stream();
        int unsigned n_pairs;
        bit          broken;
        n_pairs = $urandom_range(5);
        broken  = (n_pairs > 0) && ($urandom_range(99) < 12);
        n_streams++;
        send_beat(WORD_W'($urandom_range(16'hFFFF)), n_pairs == 0);
        for (int p = 0; p < n_pairs; p++) begin
            send_beat(pick_count(), broken && p == n_pairs - 1);
            if (!(broken && p == n_pairs - 1)) send_beat(pick_inc(), p == n_pairs - 1);
        end
    endtask

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: wrap, full run, oversize runs, zero run at end, start-only and count-ended streams
        n_streams += 4;
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd64, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'd65, 1'b0);
        send_beat(16'h7777, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'h0003, 1'b1);
        send_beat(16'h8000, 1'b1);
        send_beat(16'h0010, 1'b0);
        send_beat(16'd3, 1'b1);
        send_beat(16'h0001, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0001, 1'b1);
        settle();

        // signed counts and a small limit that cuts a run short
        apply_settings(1'b1, 32'd5);
        n_streams++;
        send_beat(16'h0100, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0002, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'd10, 1'b0);
        send_beat(16'h0100, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h0004, 1'b0);
        send_beat(16'd2, 1'b0);
        send_beat(16'h0009, 1'b1);
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph / 2)
                0:       apply_settings(ph[0], LIMIT_RST);
                1:       apply_settings(ph[0], 32'd1);
                2:       apply_settings(ph[0], LIMIT_W'($urandom_range(80, 2)));
                default: apply_settings(ph[0], LIMIT_RST);
            endcase
            tx_idle_pct  = tx_pct_tab[ph % 4];
            rx_stall_pct = rx_pct_tab[ph % 4];
            target = n_words + ITEMS_TOTAL / N_PHASES;
            while (n_words < target) send_random_stream();
            settle();
        end

        $display("Sent %0d code words in %0d streams under %0d register settings.",
                 n_words, n_streams, n_configs);
        $display("Checked %0d result beats, %0d of them status-only.", chk_results, chk_flagged);
        if (chk_errors == 0 && chk_outstanding == 0) begin
            $display("delta_rle_decoder verification clean");
        end else begin
            $display("delta_rle_decoder verification failed");
        end
        $finish;
    end

endmodule
